>>> rtl/frame_width_packer_rx_top_defines.svh
// Assertion macros for the frame width packer receive block.
// Used by the top level only; the macros sample on clk and are disabled in rst.
`ifndef FRAME_WIDTH_PACKER_RX_TOP_DEFINES_SVH
`define FRAME_WIDTH_PACKER_RX_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fwp_pkg.sv
// Shared types and constants of the frame width packer receive block.
// No dependencies; every other file of the block but the assertion macro header refers to it by scoped names.
`timescale 1ns / 1ps

package fwp_pkg;

  localparam int unsigned MAX_WORDS = 4096;
  localparam int unsigned WC_W      = 13;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned VC_W      = 4;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PTR_W   = 2;
  localparam int unsigned Q_CNT_W   = 3;

  // Configuration register indexes.
  localparam logic REG_LITTLE_ENDIAN = 1'b0;
  localparam logic REG_LANE_WIDTH    = 1'b1;

  // Result kinds.
  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    LANE_8  = 2'd0,
    LANE_16 = 2'd1,
    LANE_32 = 2'd2,
    LANE_64 = 2'd3
  } lane_t;

  // Everything one beat produces: up to two words and an optional summary.
  typedef struct packed {
    logic [1:0]       n_words;
    logic             summary;
    logic [31:0]      word0;
    logic [31:0]      word1;
    logic [IDX_W-1:0] index0;
    logic [VC_W-1:0]  vc;
    logic [WC_W-1:0]  words;
    logic             error;
  } fwp_rec_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [Q_CNT_W-1:0] count;
  } fwp_qstat_t;

endpackage

>>> rtl/fwp_front.sv
// Front part: configuration registers, frame tracking and lane packing.
// Turns each accepted beat that completes a word or ends a frame into one record for the queue. Depends on fwp_pkg.
`timescale 1ns / 1ps

module fwp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [1:0]               cfg_data,
  input  logic                     accept,
  input  logic [fwp_pkg::VC_W-1:0] vc,
  input  logic                     sof,
  input  logic                     eof,
  input  logic                     eofe,
  input  logic [31:0]              data_high,
  input  logic [31:0]              data_low,
  output logic                     push,
  output fwp_pkg::fwp_rec_t        rec
);

  logic                       little_endian;
  fwp_pkg::lane_t             lane_width;
  logic                       in_frame;
  logic [fwp_pkg::VC_W-1:0]   frame_channel;
  logic                       bad_frame;
  logic [fwp_pkg::WC_W-1:0]   word_count;
  logic [1:0]                 beat_count;
  logic [31:0]                partial_word;

  logic [fwp_pkg::VC_W-1:0]   frame_channel_next;
  logic                       bad_frame_next;
  logic [fwp_pkg::WC_W-1:0]   word_count_next;
  logic [1:0]                 beat_count_next;
  logic [31:0]                partial_word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
      lane_width    <= fwp_pkg::LANE_32;
    end else if (cfg_we) begin
      case (cfg_index)
        fwp_pkg::REG_LITTLE_ENDIAN: little_endian <= cfg_data[0];
        fwp_pkg::REG_LANE_WIDTH:    lane_width    <= fwp_pkg::lane_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [fwp_pkg::WC_W-1:0] wc0;
    logic [fwp_pkg::WC_W-1:0] wca;
    logic [31:0]              pw0;
    logic [31:0]              b;
    logic [1:0]               ph;
    logic [1:0]               byte_sh;
    logic                     want0;
    logic                     want1;
    logic                     took0;
    logic                     took1;
    logic                     partial_left;

    if (in_frame) begin
      wc0                = word_count;
      ph                 = beat_count;
      pw0                = partial_word;
      bad_frame_next     = bad_frame;
      frame_channel_next = frame_channel;
    end else begin
      wc0                = '0;
      ph                 = '0;
      pw0                = '0;
      bad_frame_next     = ~sof;
      frame_channel_next = vc;
    end
    if (vc != frame_channel_next) begin
      bad_frame_next = 1'b1;
    end

    want0             = 1'b0;
    want1             = 1'b0;
    partial_word_next = pw0;
    rec.word0         = data_low;
    rec.word1         = data_high;
    byte_sh           = little_endian ? ph : ~ph;
    b                 = {24'h0, data_low[7:0]} << {byte_sh, 3'b000};

    case (lane_width)
      fwp_pkg::LANE_64: begin
        want0 = 1'b1;
        want1 = 1'b1;
      end
      fwp_pkg::LANE_32: begin
        want0 = 1'b1;
      end
      fwp_pkg::LANE_16: begin
        if (!ph[0]) begin
          partial_word_next = little_endian ? {16'h0, data_low[15:0]}
                                            : {data_low[15:0], 16'h0};
        end else begin
          partial_word_next = pw0 | (little_endian ? {data_low[15:0], 16'h0}
                                                   : {16'h0, data_low[15:0]});
          want0     = 1'b1;
          rec.word0 = partial_word_next;
        end
      end
      fwp_pkg::LANE_8: begin
        partial_word_next = (ph == 2'd0) ? b : (pw0 | b);
        if (ph == 2'd3) begin
          want0     = 1'b1;
          rec.word0 = partial_word_next;
        end
      end
      default: ;
    endcase

    // A word that finds the store full is dropped and spoils the frame.
    took0 = want0 && (wc0 < fwp_pkg::WC_W'(fwp_pkg::MAX_WORDS));
    wca   = wc0 + fwp_pkg::WC_W'(took0);
    took1 = want1 && (wca < fwp_pkg::WC_W'(fwp_pkg::MAX_WORDS));
    if ((want0 && !took0) || (want1 && !took1)) begin
      bad_frame_next = 1'b1;
    end
    word_count_next = wca + fwp_pkg::WC_W'(took1);
    beat_count_next = ph + 2'd1;

    case (lane_width)
      fwp_pkg::LANE_8:  partial_left = (beat_count_next != 2'd0);
      fwp_pkg::LANE_16: partial_left = beat_count_next[0];
      default:          partial_left = 1'b0;
    endcase

    rec.n_words = {1'b0, took0} + {1'b0, took1};
    rec.summary = eof;
    rec.index0  = wc0[fwp_pkg::IDX_W-1:0];
    rec.vc      = frame_channel_next;
    rec.words   = word_count_next;
    rec.error   = eofe | bad_frame_next | partial_left;
    push        = accept && (took0 || eof);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      frame_channel <= '0;
      bad_frame     <= 1'b0;
      word_count    <= '0;
      beat_count    <= '0;
      partial_word  <= '0;
    end else if (accept) begin
      in_frame      <= ~eof;
      frame_channel <= frame_channel_next;
      bad_frame     <= bad_frame_next;
      word_count    <= word_count_next;
      beat_count    <= beat_count_next;
      partial_word  <= partial_word_next;
    end
  end

endmodule

>>> rtl/fwp_queue.sv
// Short record queue between the front and back parts of the packer.
// Register storage, one push and one pop per cycle. Depends on fwp_pkg.
`timescale 1ns / 1ps

module fwp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fwp_pkg::fwp_rec_t   push_rec,
  input  logic                pop,
  output fwp_pkg::fwp_rec_t   head,
  output fwp_pkg::fwp_qstat_t status
);

  fwp_pkg::fwp_rec_t                store [fwp_pkg::Q_DEPTH];
  logic [fwp_pkg::Q_PTR_W-1:0]      wr_ptr;
  logic [fwp_pkg::Q_PTR_W-1:0]      rd_ptr;
  logic [fwp_pkg::Q_CNT_W-1:0]      count;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + fwp_pkg::Q_CNT_W'(push) - fwp_pkg::Q_CNT_W'(pop);
    end
  end

  assign head         = store[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == fwp_pkg::Q_CNT_W'(fwp_pkg::Q_DEPTH));
  assign status.count = count;

endmodule

>>> rtl/fwp_back.sv
// Back part: walks the head record and presents its words, then its summary,
// one item per cycle while out_stall is low. Depends on fwp_pkg.
`timescale 1ns / 1ps

module fwp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  fwp_pkg::fwp_rec_t          head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       result_kind,
  output logic [31:0]                word_data,
  output logic [fwp_pkg::IDX_W-1:0]  word_index,
  output logic [fwp_pkg::VC_W-1:0]   frame_vc,
  output logic [fwp_pkg::WC_W-1:0]   frame_words,
  output logic                       frame_error,
  output logic                       last
);

  logic [1:0] sel;
  logic [1:0] sel_next;
  logic [1:0] n_results;
  logic       is_word;
  logic       taken;

  assign n_results = head.n_words + {1'b0, head.summary};
  assign is_word   = (sel < head.n_words);
  assign out_valid = ~empty;
  assign taken     = out_valid && !out_stall;
  assign last      = (sel == n_results - 2'd1);
  assign pop       = taken && last;
  assign sel_next  = pop ? 2'd0 : (sel + 2'd1);

  always_comb begin
    frame_vc = head.vc;
    if (is_word) begin
      result_kind = fwp_pkg::KIND_WORD;
      word_data   = sel[0] ? head.word1 : head.word0;
      word_index  = head.index0 + fwp_pkg::IDX_W'(sel[0]);
      frame_words = '0;
      frame_error = 1'b0;
    end else begin
      result_kind = fwp_pkg::KIND_SUMMARY;
      word_data   = '0;
      word_index  = '0;
      frame_words = head.words;
      frame_error = head.error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else if (taken) begin
      sel <= sel_next;
    end
  end

endmodule

>>> rtl/frame_width_packer_rx_top.sv
// Frame width packer, receive side: packs 8/16/32/64-bit lane beats into 32-bit words.
// Each record pushed by an accepted beat is registered in the queue and shows its results at the head.
// The input takes one beat per cycle while the queue is not full; the output port moves one result
// per cycle while out_stall is low, so a beat with two or three results leaves the queue after its last.
// The four-entry record queue sets how long the input can run ahead of the output.
// Synchronous reset clears frame state and the queue; config resets to big endian, 32-bit.
`timescale 1ns / 1ps
`include "frame_width_packer_rx_top_defines.svh"

module frame_width_packer_rx_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [1:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fwp_pkg::VC_W-1:0]   vc,
  input  logic                       sof,
  input  logic                       eof,
  input  logic                       eofe,
  input  logic [31:0]                data_high,
  input  logic [31:0]                data_low,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       result_kind,
  output logic [31:0]                word_data,
  output logic [fwp_pkg::IDX_W-1:0]  word_index,
  output logic [fwp_pkg::VC_W-1:0]   frame_vc,
  output logic [fwp_pkg::WC_W-1:0]   frame_words,
  output logic                       frame_error,
  output logic                       last
);

  fwp_pkg::fwp_rec_t   rec;
  fwp_pkg::fwp_rec_t   head;
  fwp_pkg::fwp_qstat_t qstat;
  logic                push;
  logic                pop;
  logic                accept;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  fwp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .vc        (vc),
    .sof       (sof),
    .eof       (eof),
    .eofe      (eofe),
    .data_high (data_high),
    .data_low  (data_low),
    .push      (push),
    .rec       (rec)
  );

  fwp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (rec),
    .pop      (pop),
    .head     (head),
    .status   (qstat)
  );

  fwp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (qstat.empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .word_data   (word_data),
    .word_index  (word_index),
    .frame_vc    (frame_vc),
    .frame_words (frame_words),
    .frame_error (frame_error),
    .last        (last)
  );

  // The queue count never goes past its depth.
  `FWP_ASSERT_SAME(a_queue_bound, 1'b1, qstat.count <= fwp_pkg::Q_CNT_W'(fwp_pkg::Q_DEPTH), "queue count past depth")
  // A frame summary always closes the results of its beat.
  `FWP_ASSERT_SAME(a_summary_last, out_valid && result_kind == fwp_pkg::KIND_SUMMARY, last, "summary not marked last")
  // A taken result that is not the last of its beat is followed by another one.
  `FWP_ASSERT_NEXT(a_more_follow, out_valid && !out_stall && !last, out_valid, "missing result after non-last item")

endmodule
